[hw/rtl/rsd_pkg.sv]
// rsd_pkg: shared types, constants and helpers for the rtc snapshot
// stabilize and decode unit. No dependencies.
package rsd_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned YearW    = 15;
   localparam int unsigned HourW    = 7;
   localparam int unsigned CountW   = 8;
   localparam int unsigned SnapW    = 64;
   localparam int unsigned RspDataW = 56;

   localparam logic [ByteW-1:0]  MaxPairsReset = 8'd8;
   localparam logic [ByteW-1:0]  SbBinaryMask  = 8'h04;
   localparam logic [ByteW-1:0]  SbH24Mask     = 8'h02;
   localparam logic [ByteW-1:0]  HourPmMask    = 8'h80;
   localparam logic [ByteW-1:0]  HourValMask   = 8'h7F;
   localparam logic [ByteW-1:0]  CenAbsentHi   = 8'hFF;
   localparam logic [ByteW-1:0]  YearWindow    = 8'd70;
   localparam logic [YearW-1:0]  Base1900      = 15'd1900;
   localparam logic [YearW-1:0]  Base2000      = 15'd2000;
   localparam logic [ByteW-1:0]  CenScale      = 8'd100;
   localparam logic [HourW-1:0]  HalfDay       = 7'd12;

   // first listed member sits in the highest bits of a packed struct
   typedef struct packed {
      logic [ByteW-1:0] century;
      logic [ByteW-1:0] status_b;
      logic [ByteW-1:0] year;
      logic [ByteW-1:0] month;
      logic [ByteW-1:0] day;
      logic [ByteW-1:0] hour;
      logic [ByteW-1:0] minute;
      logic [ByteW-1:0] second;
   } snap_type;

   typedef struct packed {
      logic [1:0]       pad;
      logic [ByteW-1:0] second_out;
      logic [ByteW-1:0] minute;
      logic [HourW-1:0] hour;
      logic [ByteW-1:0] day;
      logic [ByteW-1:0] month;
      logic [YearW-1:0] cal_year;
   } rsp_data_type;

   typedef struct packed {
      logic emit;
      logic ok;
   } pair_ctrl_type;

   // unchecked bcd: low + 10 * high
   function automatic logic [ByteW-1:0] bcd_value(input logic [ByteW-1:0] v);
      logic [ByteW-1:0] hi;
      hi = {4'd0, v[7:4]};
      return {4'd0, v[3:0]} + (hi << 3) + (hi << 1);
   endfunction

endpackage

[hw/rtl/rsd_pair_check.sv]
// rsd_pair_check: holds the first snapshot of a pair, compares the second,
// counts mismatched pairs and holds the max_pairs register. Uses rsd_pkg.
module rsd_pair_check (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [rsd_pkg::ByteW-1:0]   csr_wdata,
   input  logic                        fire,
   input  rsd_pkg::snap_type           snap,
   output rsd_pkg::pair_ctrl_type      ctrl
);
   import rsd_pkg::*;

   logic [ByteW-1:0]  max_pairs_ff, max_pairs_in;
   snap_type          first_ff, first_in;
   logic              have_first_ff, have_first_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [CountW:0]   count_inc;
   logic              fail;

   assign count_inc = {1'b0, count_ff} + {{CountW{1'b0}}, 1'b1};
   // zero limit acts like one since the incremented count is never zero
   assign fail = count_inc >= {1'b0, max_pairs_ff};

   always_comb begin
      max_pairs_in  = csr_we ? csr_wdata : max_pairs_ff;
      first_in      = first_ff;
      have_first_in = have_first_ff;
      count_in      = count_ff;
      ctrl.emit     = 1'b0;
      ctrl.ok       = 1'b0;
      if (!have_first_ff) begin
         first_in      = snap;
         have_first_in = 1'b1;
      end else if (snap != first_ff) begin
         have_first_in = 1'b0;
         ctrl.emit     = fail;
         count_in      = fail ? '0 : count_inc[CountW-1:0];
      end else begin
         have_first_in = 1'b0;
         ctrl.emit     = 1'b1;
         ctrl.ok       = 1'b1;
         count_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff  <= MaxPairsReset;
         first_ff      <= '0;
         have_first_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         max_pairs_ff <= max_pairs_in;
         if (fire) begin
            first_ff      <= first_in;
            have_first_ff <= have_first_in;
            count_ff      <= count_in;
         end
      end
   end

endmodule

[hw/rtl/rsd_time_decode.sv]
// rsd_time_decode: bcd or binary, 12/24-hour and full-year decode of one snapshot.
// Uses rsd_pkg.
module rsd_time_decode (
   input  rsd_pkg::snap_type      snap,
   output rsd_pkg::rsp_data_type  dec
);
   import rsd_pkg::*;

   logic             binary, h24, pm, cen_ok;
   logic [ByteW-1:0] sec, min, day, mon, yr, cen;
   logic [HourW-1:0] hr;
   logic [YearW-1:0] fy;

   assign binary = |(snap.status_b & SbBinaryMask);
   assign h24    = |(snap.status_b & SbH24Mask);
   assign pm     = |(snap.hour & HourPmMask);
   assign cen_ok = (snap.century != '0) && (snap.century != CenAbsentHi);

   always_comb begin
      logic [ByteW-1:0] hr_raw;
      logic [ByteW-1:0] hr_bcd;
      hr_raw = snap.hour & HourValMask;
      hr_bcd = bcd_value(hr_raw);
      if (binary) begin
         sec = snap.second;
         min = snap.minute;
         day = snap.day;
         mon = snap.month;
         yr  = snap.year;
         cen = snap.century;
         hr  = hr_raw[HourW-1:0];
      end else begin
         sec = bcd_value(snap.second);
         min = bcd_value(snap.minute);
         day = bcd_value(snap.day);
         mon = bcd_value(snap.month);
         yr  = bcd_value(snap.year);
         cen = cen_ok ? bcd_value(snap.century) : snap.century;
         hr  = hr_bcd[HourW-1:0];
      end
      if (!h24) begin
         if (pm && hr < HalfDay) begin
            hr = hr + HalfDay;
         end else if (!pm && hr == HalfDay) begin
            hr = '0;
         end
      end
      if (cen_ok) begin
         fy = YearW'({7'd0, cen} * {7'd0, CenScale}) + {7'd0, yr};
      end else if (yr >= YearWindow) begin
         fy = Base1900 + {7'd0, yr};
      end else begin
         fy = Base2000 + {7'd0, yr};
      end
   end

   always_comb begin
      dec            = '0;
      dec.cal_year   = fy;
      dec.month      = mon;
      dec.day        = day;
      dec.hour       = hr;
      dec.minute     = min;
      dec.second_out = sec;
   end

endmodule

[hw/rtl/rtc_snapshot_stabilize_decode_unit.sv]
// rtc_snapshot_stabilize_decode_unit: top level with input and result
// registers around rsd_pair_check and rsd_time_decode. Uses rsd_pkg.
//
//   channel   ports            beat contents
//   req       req_t*           one raw snapshot of eight register bytes
//   rsp       rsp_t*           decoded time (tuser 1) or failure (tuser 0)
//   csr       csr_we/wdata     max_pairs
//
// one snapshot a cycle while the result register can take beats; each beat
// waits in the input register until it advances, and the second beat of a
// matching pair, or a failure at the max_pairs limit, moves on to the result register.
// the input register moves on when the result register is empty or drained
// in that cycle, so a stalled rsp side holds back req after one beat.
// synchronous reset clears valids and the pair state and sets max_pairs to 8.
module rtc_snapshot_stabilize_decode_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // second, minute, hour, day, month, year, status_b, century
   input  logic [rsd_pkg::SnapW-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cal_year, month, day, hour, minute, second_out, 2 zero bits
   output logic [rsd_pkg::RspDataW-1:0]   rsp_tdata,
   // ok
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [rsd_pkg::ByteW-1:0]      csr_wdata
);
   import rsd_pkg::*;

   snap_type      in_data_ff;
   logic          in_valid_ff, in_valid_in;
   logic          advance;
   pair_ctrl_type ctrl;
   rsp_data_type  dec;
   rsp_data_type  out_data_ff;
   logic          out_ok_ff;
   logic          out_valid_ff, out_valid_in;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = (advance && ctrl.emit) ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   rsd_pair_check u_pair_check (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .fire      (advance),
      .snap      (in_data_ff),
      .ctrl      (ctrl)
   );

   rsd_time_decode u_time_decode (
      .snap (in_data_ff),
      .dec  (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= snap_type'(req_tdata);
      end
      if (advance && ctrl.emit) begin
         // failure beats carry all-zero fields
         out_data_ff <= ctrl.ok ? dec : '0;
         out_ok_ff   <= ctrl.ok;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ok_ff;

endmodule
